[src/rscu_pkg.sv]
package rscu_pkg;

  localparam int unsigned FIELD_W   = 16;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned VOL_W     = 48;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_PLACE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LEN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN_Z = 2'd2;

endpackage

[src/rscu_if.sv]
interface rscu_in_if import rscu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [FIELD_W-1:0]   block_x;
  logic [FIELD_W-1:0]   block_y;
  logic [FIELD_W-1:0]   block_z;
  logic [FIELD_W-1:0]   block_len_x;
  logic [FIELD_W-1:0]   block_len_y;
  logic [FIELD_W-1:0]   block_len_z;
  logic [IDX_W-1:0]     entry_index;

  modport source(output valid, operation, block_x, block_y, block_z, block_len_x,
                 block_len_y, block_len_z, entry_index, input ready);
  modport sink(input valid, operation, block_x, block_y, block_z, block_len_x,
               block_len_y, block_len_z, entry_index, output ready);
endinterface

interface rscu_out_if import rscu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STAT_W-1:0]    status;
  logic [CNT_W-1:0]     space_count;
  logic [FIELD_W-1:0]   space_x;
  logic [FIELD_W-1:0]   space_y;
  logic [FIELD_W-1:0]   space_z;
  logic [FIELD_W-1:0]   space_len_x;
  logic [FIELD_W-1:0]   space_len_y;
  logic [FIELD_W-1:0]   space_len_z;
  logic [VOL_W-1:0]     space_volume;

  modport source(output valid, status, space_count, space_x, space_y, space_z,
                 space_len_x, space_len_y, space_len_z, space_volume, input ready);
  modport sink(input valid, status, space_count, space_x, space_y, space_z,
               space_len_x, space_len_y, space_len_z, space_volume, output ready);
endinterface

interface rscu_cfg_if import rscu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [FIELD_W-1:0]   data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[src/rscu_ram.sv]
module rscu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/rscu_vol.sv]
module rscu_vol #(
  parameter int unsigned CB = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [CB-1:0] len_x_i,
  input  logic [CB-1:0] len_y_i,
  input  logic [CB-1:0] len_z_i,
  output logic          done_o,
  output logic [3*CB-1:0] vol_o
);

  // Three stages: x*y, then the two halves of that product times z, then the sum.
  logic [2:0]      vld_q;
  logic [2*CB-1:0] prod_xy_q;
  logic [CB-1:0]   lz_q;
  logic [2*CB-1:0] part_lo_q;
  logic [2*CB-1:0] part_hi_q;
  logic [3*CB-1:0] vol_q;
  logic [2*CB-1:0] prod_xy_d;
  logic [2*CB-1:0] part_lo_d;
  logic [2*CB-1:0] part_hi_d;
  logic [3*CB-1:0] vol_d;

  assign prod_xy_d = len_x_i * len_y_i;
  assign part_lo_d = prod_xy_q[CB-1:0] * lz_q;
  assign part_hi_d = prod_xy_q[2*CB-1:CB] * lz_q;
  assign vol_d     = {part_hi_q, {CB{1'b0}}} + (3*CB)'(part_lo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    prod_xy_q <= prod_xy_d;
    lz_q      <= len_z_i;
    part_lo_q <= part_lo_d;
    part_hi_q <= part_hi_d;
    vol_q     <= vol_d;
  end

  assign done_o = vld_q[2];
  assign vol_o  = vol_q;

endmodule

[src/residual_space_cover_update_unit.sv]
// Free-space table for 3D packing, holding overlapping maximal spaces.
// Channels: in_i takes one operation per transaction (clear, place, read),
// out_o returns exactly one result transaction for each, and cfg_i writes
// the three container lengths, which are used by the clear operation.
// Items are handled one at a time; in_i is ready only when the sequencer
// is idle. A place operation walks the table (fetching each space, then
// examining each box, which is the space itself when the block misses
// it and otherwise its six candidate residuals, and computing the volume
// of each box written to scratch), then checks every scratch box against
// every other through the single read port of the scratch memory. The
// scratch port sets the place latency.
// The result sits in an output register; a stalled receiver holds it, and
// the next operation may be accepted and processed meanwhile, waiting at
// its end until the register is free.
// Reset empties the table and sets every container length to one; the
// memories need no clearing, only entries below the count are read.
module residual_space_cover_update_unit import rscu_pkg::*; #(
  parameter int unsigned MAX_SPACES     = 64,
  parameter int unsigned SCRATCH_SPACES = 256,
  parameter int unsigned COORD_BITS     = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rscu_in_if.sink    in_i,
  rscu_out_if.source out_o,
  rscu_cfg_if.sink   cfg_i
);

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned BOX_W = 6 * CB;
  localparam int unsigned V_W   = 3 * CB;
  localparam int unsigned SA_W  = $clog2(MAX_SPACES);
  localparam int unsigned SC_W  = $clog2(SCRATCH_SPACES);
  localparam int unsigned TOT_W = $clog2(MAX_SPACES + 1);
  localparam int unsigned N_W   = $clog2(SCRATCH_SPACES + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_ISSUE, ST_RD_WAIT, ST_RD_VOL, ST_P1_ISSUE, ST_P1_LOAD,
    ST_P1_GEN, ST_P1_VOL, ST_P2_ISSUE, ST_P2_LOAD, ST_P2_SCAN, ST_P2_WRITE,
    ST_DONE
  } state_e;

  function automatic logic [CB-1:0] fld(input logic [BOX_W-1:0] b, input int unsigned f);
    return b[f*CB +: CB];
  endfunction

  // True when box bj at position jdx is checked before box bi at idx.
  function automatic logic precedes(input logic [BOX_W-1:0] bj, input logic [V_W-1:0] vj,
                                    input logic [N_W-1:0] jdx,
                                    input logic [BOX_W-1:0] bi, input logic [V_W-1:0] vi,
                                    input logic [N_W-1:0] idx);
    logic res;
    logic found;
    res   = 1'b0;
    found = 1'b0;
    if (vj != vi) begin
      res   = vj > vi;
      found = 1'b1;
    end
    for (int unsigned f = 0; f < 6; f++) begin
      if (!found && fld(bj, f) != fld(bi, f)) begin
        res   = fld(bj, f) < fld(bi, f);
        found = 1'b1;
      end
    end
    if (!found) begin
      res = jdx < idx;
    end
    return res;
  endfunction

  function automatic logic contains(input logic [BOX_W-1:0] a, input logic [BOX_W-1:0] b);
    logic ok;
    ok = 1'b1;
    for (int unsigned k = 0; k < 3; k++) begin
      if (fld(a, k) > fld(b, k)) begin
        ok = 1'b0;
      end
      if ((CB+1)'(fld(b, k)) + (CB+1)'(fld(b, k+3)) >
          (CB+1)'(fld(a, k)) + (CB+1)'(fld(a, k+3))) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // Control state
  state_e           state_q, state_d;
  logic [CB-1:0]    clen_q [3];
  logic [CB-1:0]    clen_d [3];
  logic [TOT_W-1:0] total_q, total_d;
  logic             out_valid_q, out_valid_d;
  logic [TOT_W-1:0] s_q, s_d;
  logic [2:0]       cand_q, cand_d;
  logic [N_W-1:0]   n_q, n_d;
  logic [N_W-1:0]   i_q, i_d;
  logic [N_W-1:0]   j_q, j_d;
  logic             cmp_v_q, cmp_v_d;
  logic [TOT_W-1:0] w_q, w_d;
  logic             ovf_q, ovf_d;

  // Payload
  logic [OP_W-1:0]   op_q, op_d;
  logic [CB-1:0]     bmin_q [3];
  logic [CB-1:0]     bmin_d [3];
  logic [CB-1:0]     blen_q [3];
  logic [CB-1:0]     blen_d [3];
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [BOX_W-1:0]  rbox_q, rbox_d;
  logic              hit_q, hit_d;
  logic [CB:0]       cmin_q [3];
  logic [CB:0]       cmin_d [3];
  logic [CB:0]       cmax_q [3];
  logic [CB:0]       cmax_d [3];
  logic [CB:0]       rmax_q [3];
  logic [CB:0]       rmax_d [3];
  logic [BOX_W-1:0]  cbox_q, cbox_d;
  logic [BOX_W-1:0]  bi_q, bi_d;
  logic [V_W-1:0]    vi_q, vi_d;
  logic [N_W-1:0]    cmp_idx_q, cmp_idx_d;
  logic              drop_q, drop_d;
  logic [STAT_W-1:0] res_stat_q, res_stat_d;
  logic [BOX_W-1:0]  res_box_q, res_box_d;
  logic [V_W-1:0]    res_vol_q, res_vol_d;
  logic [STAT_W-1:0] o_stat_q, o_stat_d;
  logic [CNT_W-1:0]  o_cnt_q, o_cnt_d;
  logic [BOX_W-1:0]  o_box_q, o_box_d;
  logic [VOL_W-1:0]  o_vol_q, o_vol_d;

  // Memories and volume unit
  logic             sp_we;
  logic [SA_W-1:0]  sp_waddr, sp_raddr;
  logic [BOX_W-1:0] sp_wdata, sp_rdata;
  logic             sc_we;
  logic [SC_W-1:0]  sc_waddr, sc_raddr;
  logic [BOX_W-1:0] sc_rdata;
  logic [V_W-1:0]   scv_rdata;
  logic             vol_start, vol_done;
  logic [CB-1:0]    vol_len [3];
  logic [V_W-1:0]   vol_res;

  rscu_ram #(.WIDTH(BOX_W), .DEPTH(MAX_SPACES)) u_space_ram (
    .clk_i, .we_i(sp_we), .waddr_i(sp_waddr), .wdata_i(sp_wdata),
    .raddr_i(sp_raddr), .rdata_o(sp_rdata)
  );

  rscu_ram #(.WIDTH(BOX_W), .DEPTH(SCRATCH_SPACES)) u_scratch_ram (
    .clk_i, .we_i(sc_we), .waddr_i(sc_waddr), .wdata_i(cbox_q),
    .raddr_i(sc_raddr), .rdata_o(sc_rdata)
  );

  rscu_ram #(.WIDTH(V_W), .DEPTH(SCRATCH_SPACES)) u_scratch_vol_ram (
    .clk_i, .we_i(sc_we), .waddr_i(sc_waddr), .wdata_i(vol_res),
    .raddr_i(sc_raddr), .rdata_o(scv_rdata)
  );

  rscu_vol #(.CB(CB)) u_vol (
    .clk_i, .rst_ni, .start_i(vol_start),
    .len_x_i(vol_len[0]), .len_y_i(vol_len[1]), .len_z_i(vol_len[2]),
    .done_o(vol_done), .vol_o(vol_res)
  );

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  always_comb begin
    logic [CB-1:0] rp;
    logic [CB-1:0] rl;
    logic [CB:0]   bmax;
    logic [1:0]    k;
    logic          cvalid;
    logic          adv;
    logic          to_p2;
    logic [CB:0]   diff;

    state_d     = state_q;
    clen_d      = clen_q;
    total_d     = total_q;
    out_valid_d = out_valid_q;
    s_d         = s_q;
    cand_d      = cand_q;
    n_d         = n_q;
    i_d         = i_q;
    j_d         = j_q;
    cmp_v_d     = cmp_v_q;
    w_d         = w_q;
    ovf_d       = ovf_q;
    op_d        = op_q;
    bmin_d      = bmin_q;
    blen_d      = blen_q;
    idx_d       = idx_q;
    rbox_d      = rbox_q;
    hit_d       = hit_q;
    cmin_d      = cmin_q;
    cmax_d      = cmax_q;
    rmax_d      = rmax_q;
    cbox_d      = cbox_q;
    bi_d        = bi_q;
    vi_d        = vi_q;
    cmp_idx_d   = cmp_idx_q;
    drop_d      = drop_q;
    res_stat_d  = res_stat_q;
    res_box_d   = res_box_q;
    res_vol_d   = res_vol_q;
    o_stat_d    = o_stat_q;
    o_cnt_d     = o_cnt_q;
    o_box_d     = o_box_q;
    o_vol_d     = o_vol_q;

    sp_we     = 1'b0;
    sp_waddr  = w_q[SA_W-1:0];
    sp_wdata  = bi_q;
    sp_raddr  = s_q[SA_W-1:0];
    sc_we     = 1'b0;
    sc_waddr  = n_q[SC_W-1:0];
    sc_raddr  = i_q[SC_W-1:0];
    vol_start = 1'b0;
    for (int unsigned a = 0; a < 3; a++) begin
      vol_len[a] = fld(cbox_q, a + 3);
    end

    rp     = '0;
    rl     = '0;
    bmax   = '0;
    k      = cand_q[2:1];
    cvalid = 1'b0;
    adv    = 1'b0;
    to_p2  = 1'b0;
    diff   = '0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_LEN_X: clen_d[0] = CB'(cfg_i.data);
        CFG_LEN_Y: clen_d[1] = CB'(cfg_i.data);
        CFG_LEN_Z: clen_d[2] = CB'(cfg_i.data);
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          op_d       = in_i.operation;
          bmin_d[0]  = CB'(in_i.block_x);
          bmin_d[1]  = CB'(in_i.block_y);
          bmin_d[2]  = CB'(in_i.block_z);
          blen_d[0]  = CB'(in_i.block_len_x);
          blen_d[1]  = CB'(in_i.block_len_y);
          blen_d[2]  = CB'(in_i.block_len_z);
          idx_d      = in_i.entry_index;
          res_stat_d = STAT_OK;
          res_box_d  = '0;
          res_vol_d  = '0;
          ovf_d      = 1'b0;
          state_d    = ST_DONE;
          case (in_i.operation)
            OP_CLEAR: begin
              sp_we    = 1'b1;
              sp_waddr = '0;
              sp_wdata = {clen_q[2], clen_q[1], clen_q[0], {(3*CB){1'b0}}};
              total_d  = TOT_W'(1);
            end
            OP_PLACE: begin
              s_d    = '0;
              n_d    = '0;
              cand_d = '0;
              if (total_q == '0) begin
                total_d = '0;
              end else begin
                state_d = ST_P1_ISSUE;
              end
            end
            OP_READ: begin
              if (32'(in_i.entry_index) < 32'(total_q)) begin
                state_d = ST_RD_ISSUE;
              end else begin
                res_stat_d = STAT_RANGE;
              end
            end
            default: ;
          endcase
        end
      end

      ST_RD_ISSUE: begin
        sp_raddr = SA_W'(idx_q);
        state_d  = ST_RD_WAIT;
      end

      ST_RD_WAIT: begin
        res_box_d = sp_rdata;
        vol_start = 1'b1;
        for (int unsigned a = 0; a < 3; a++) begin
          vol_len[a] = fld(sp_rdata, a + 3);
        end
        state_d = ST_RD_VOL;
      end

      ST_RD_VOL: begin
        if (vol_done) begin
          res_vol_d = vol_res;
          state_d   = ST_DONE;
        end
      end

      ST_P1_ISSUE: begin
        state_d = ST_P1_LOAD;
      end

      ST_P1_LOAD: begin
        rbox_d = sp_rdata;
        hit_d  = 1'b1;
        for (int unsigned a = 0; a < 3; a++) begin
          rp        = fld(sp_rdata, a);
          rl        = fld(sp_rdata, a + 3);
          rmax_d[a] = (CB+1)'(rp) + (CB+1)'(rl);
          bmax      = (CB+1)'(bmin_q[a]) + (CB+1)'(blen_q[a]);
          cmin_d[a] = (rp > bmin_q[a]) ? (CB+1)'(rp) : (CB+1)'(bmin_q[a]);
          cmax_d[a] = (rmax_d[a] < bmax) ? rmax_d[a] : bmax;
          if (cmin_d[a] >= cmax_d[a]) begin
            hit_d = 1'b0;
          end
        end
        cand_d  = '0;
        state_d = ST_P1_GEN;
      end

      ST_P1_GEN: begin
        cbox_d = rbox_q;
        if (!hit_q) begin
          cvalid = 1'b1;
        end else if (!cand_q[0]) begin
          // Residual on the far side of the block along axis k.
          cvalid = cmax_q[k] < rmax_q[k];
          diff   = rmax_q[k] - cmax_q[k];
          cbox_d[32'(k)*CB +: CB]       = cmax_q[k][CB-1:0];
          cbox_d[(32'(k)+3)*CB +: CB]   = diff[CB-1:0];
        end else begin
          // Residual on the near side of the block along axis k.
          cvalid = cmin_q[k] > (CB+1)'(fld(rbox_q, 32'(k)));
          diff   = cmin_q[k] - (CB+1)'(fld(rbox_q, 32'(k)));
          cbox_d[(32'(k)+3)*CB +: CB]   = diff[CB-1:0];
        end
        if (cvalid) begin
          vol_start = 1'b1;
          for (int unsigned a = 0; a < 3; a++) begin
            vol_len[a] = fld(cbox_d, a + 3);
          end
          state_d = ST_P1_VOL;
        end else begin
          adv = 1'b1;
        end
      end

      ST_P1_VOL: begin
        if (vol_done) begin
          if (32'(n_q) < SCRATCH_SPACES) begin
            sc_we = 1'b1;
            n_d   = n_q + N_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          adv = 1'b1;
        end
      end

      ST_P2_ISSUE: begin
        sc_raddr = i_q[SC_W-1:0];
        state_d  = ST_P2_LOAD;
      end

      ST_P2_LOAD: begin
        bi_d    = sc_rdata;
        vi_d    = scv_rdata;
        j_d     = '0;
        cmp_v_d = 1'b0;
        drop_d  = 1'b0;
        state_d = ST_P2_SCAN;
      end

      ST_P2_SCAN: begin
        // A box goes when any box checked before it contains it; the
        // containing one is then either kept or dropped by one that is.
        if (j_q < n_q) begin
          sc_raddr  = j_q[SC_W-1:0];
          cmp_v_d   = 1'b1;
          cmp_idx_d = j_q;
          j_d       = j_q + N_W'(1);
        end else begin
          cmp_v_d = 1'b0;
        end
        if (cmp_v_q && cmp_idx_q != i_q &&
            precedes(sc_rdata, scv_rdata, cmp_idx_q, bi_q, vi_q, i_q) &&
            contains(sc_rdata, bi_q)) begin
          drop_d = 1'b1;
        end
        if (j_q == n_q && !cmp_v_q) begin
          state_d = ST_P2_WRITE;
        end
      end

      ST_P2_WRITE: begin
        if (!drop_q) begin
          if (32'(w_q) < MAX_SPACES) begin
            sp_we    = 1'b1;
            sp_waddr = w_q[SA_W-1:0];
            sp_wdata = bi_q;
            w_d      = w_q + TOT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        i_d = i_q + N_W'(1);
        if (i_d == n_q) begin
          total_d = w_d;
          state_d = ST_DONE;
        end else begin
          state_d = ST_P2_ISSUE;
        end
      end

      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          o_stat_d    = (op_q == OP_PLACE && ovf_q) ? STAT_OVERFLOW : res_stat_q;
          o_cnt_d     = CNT_W'(total_q);
          o_box_d     = res_box_q;
          o_vol_d     = VOL_W'(res_vol_q);
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    if (adv) begin
      if (hit_q && cand_q != 3'd5) begin
        cand_d  = cand_q + 3'd1;
        state_d = ST_P1_GEN;
      end else begin
        cand_d = '0;
        if (s_q + TOT_W'(1) == total_q) begin
          to_p2 = 1'b1;
        end else begin
          s_d     = s_q + TOT_W'(1);
          state_d = ST_P1_ISSUE;
        end
      end
    end

    if (to_p2) begin
      i_d = '0;
      w_d = '0;
      if (n_d == '0) begin
        total_d = '0;
        state_d = ST_DONE;
      end else begin
        state_d = ST_P2_ISSUE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      clen_q      <= '{default: CB'(1)};
      total_q     <= '0;
      out_valid_q <= 1'b0;
      s_q         <= '0;
      cand_q      <= '0;
      n_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      cmp_v_q     <= 1'b0;
      w_q         <= '0;
      ovf_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      clen_q      <= clen_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      s_q         <= s_d;
      cand_q      <= cand_d;
      n_q         <= n_d;
      i_q         <= i_d;
      j_q         <= j_d;
      cmp_v_q     <= cmp_v_d;
      w_q         <= w_d;
      ovf_q       <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    bmin_q     <= bmin_d;
    blen_q     <= blen_d;
    idx_q      <= idx_d;
    rbox_q     <= rbox_d;
    hit_q      <= hit_d;
    cmin_q     <= cmin_d;
    cmax_q     <= cmax_d;
    rmax_q     <= rmax_d;
    cbox_q     <= cbox_d;
    bi_q       <= bi_d;
    vi_q       <= vi_d;
    cmp_idx_q  <= cmp_idx_d;
    drop_q     <= drop_d;
    res_stat_q <= res_stat_d;
    res_box_q  <= res_box_d;
    res_vol_q  <= res_vol_d;
    o_stat_q   <= o_stat_d;
    o_cnt_q    <= o_cnt_d;
    o_box_q    <= o_box_d;
    o_vol_q    <= o_vol_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = o_stat_q;
  assign out_o.space_count  = o_cnt_q;
  assign out_o.space_x      = FIELD_W'(fld(o_box_q, 0));
  assign out_o.space_y      = FIELD_W'(fld(o_box_q, 1));
  assign out_o.space_z      = FIELD_W'(fld(o_box_q, 2));
  assign out_o.space_len_x  = FIELD_W'(fld(o_box_q, 3));
  assign out_o.space_len_y  = FIELD_W'(fld(o_box_q, 4));
  assign out_o.space_len_z  = FIELD_W'(fld(o_box_q, 5));
  assign out_o.space_volume = o_vol_q;

endmodule
